### hdl/conv3x3_sharpen_edge_sobel_top_assert.svh
// Assertion macros for the 3x3 filter block checks.
`ifndef CONV3X3_SHARPEN_EDGE_SOBEL_TOP_ASSERT_SVH
`define CONV3X3_SHARPEN_EDGE_SOBEL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define CSES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cses check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define CSES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cses check failed");

`endif

### hdl/cses_pkg.sv
// Shared types, constants and arithmetic helpers for the 3x3 filter block.
package cses_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 13;
    localparam int CNT_W      = 23;
    localparam int THR_W      = 11;
    localparam int PIX_W      = 24;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_ROWS   = 4096;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        MODE_SHARPEN,
        MODE_EDGE,
        MODE_SOBEL,
        MODE_GRAY
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_WIDTH,
        REG_HEIGHT,
        REG_THRESH
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_SHIFT,
        ST_LUMA,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0] r0;
        logic [1:0] r2;
        logic [1:0] c0;
        logic [1:0] c1;
        logic [1:0] c2;
    } win_sel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic ld_item;
        logic ld_sel1;
        logic clr_cnt;
        logic rd_en;
        logic do_shift;
        logic do_emit;
        logic flush_out;
        logic start_second;
    } ctrl_t;

    function automatic logic [7:0] luma(input logic [PIX_W-1:0] p);
        logic [25:0] s;
        s = 26'd19595 * 26'(p[23:16]) + 26'd38470 * 26'(p[15:8])
            + 26'd7471 * 26'(p[7:0]);
        return s[23:16];
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

### hdl/cses_if.sv
// Stream channel interfaces for pixel input and filtered output.
interface cses_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;

    modport source (output valid, output opcode, output pix_red, output pix_green,
                    output pix_blue, input ready);
    modport sink (input valid, input opcode, input pix_red, input pix_green,
                  input pix_blue, output ready);
endinterface

interface cses_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_run;
    logic       frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output last_of_run, output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input last_of_run, input frame_end, output ready);
endinterface

### hdl/conv3x3_sharpen_edge_sobel_top.sv
// 3x3 sharpen / edge / sobel / grayscale filter over a raster RGB stream.
//
// channel   dir  beat
// in_ch     in   opcode (pixel or drain), pix_red, pix_green, pix_blue
// out_ch    out  out_red, out_green, out_blue, last_of_run, frame_end
// cfg       in   cfg_we, cfg_index, cfg_wdata (mode, width, height, threshold)
//
// One item at a time: accept in idle, then per line position a memory read and a
// shift/write-back; each result passes through luma, gradient, square, 8-step square
// root and emit, plus another pass through the read state when it comes before the shift.
// Line memory needs no clearing after reset; reset clears counters and window.
// A stalled output holds in the output register while the next result is formed.
module conv3x3_sharpen_edge_sobel_top
    import cses_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cses_in_if.sink               in_ch,
    cses_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    mode_t                    mode_reg;
    logic [WIDTH_W-1:0]       width_reg;
    logic [HEIGHT_W-1:0]      height_reg;
    logic signed [THR_W-1:0]  thresh_reg;
    logic [WIDTH_W-1:0]       eff_w;
    logic [HEIGHT_W-1:0]      eff_h;
    logic [CNT_W-1:0]         frame_last_reg;
    logic [WIDTH_W+HEIGHT_W-1:0] frame_size;

    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [CNT_W-1:0]         count_reg;

    state_t                   state_reg;
    state_t                   state_next;
    ctrl_t                    ctrl;

    logic                     op_reg;
    logic [PIX_W-1:0]         pix_reg;
    logic                     second_reg;
    logic                     first_done_reg;
    logic                     emit_first_reg;
    win_sel_t                 sel_reg;

    logic [PIX_W-1:0]         win_reg [3][3];
    logic [LINE_W-1:0]        line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]        rd_data_reg;

    logic [7:0]               l_reg [3][3];
    logic [PIX_W-1:0]         sharp_reg;
    logic                     edge_reg;
    logic [7:0]               ax_reg;
    logic [7:0]               ay_reg;
    logic [15:0]              sq_v_reg;
    logic                     sat_reg;
    logic [8:0]               rem_reg;
    logic [7:0]               root_reg;
    logic [2:0]               step_reg;

    result_t                  pend_reg;
    logic                     pend_valid_reg;
    result_t                  out_reg;
    logic                     out_last_reg;
    logic                     out_valid_reg;

    logic                     col_is0;
    logic                     row_past;
    logic                     row_ge_h;
    logic                     need_emit1;
    logic                     need_emit2;
    logic                     slot_free;
    logic                     accept;
    logic                     go;
    logic                     col_wrap;

    logic [PIX_W-1:0]         k [3][3];
    logic [1:0]               ri [3];
    logic [1:0]               cj [3];
    logic [7:0]               l_next [3][3];
    logic [PIX_W-1:0]         sharp_next;
    logic [THR_W-1:0]         lap;
    logic [THR_W-1:0]         gx;
    logic [THR_W-1:0]         gy;
    logic [16:0]              sq_sum;
    logic [10:0]              trial;
    logic [10:0]              test;
    logic [PIX_W-1:0]         mid_pix;
    logic [PIX_W-1:0]         new_pix;
    result_t                  res;
    logic [7:0]               gray_val;

    // geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
        else if (height_reg > HEIGHT_W'(MAX_ROWS))
        begin
            eff_h = HEIGHT_W'(MAX_ROWS);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign frame_size = (WIDTH_W+HEIGHT_W)'(eff_w) * (WIDTH_W+HEIGHT_W)'(eff_h);

    assign col_is0    = (col_reg == '0);
    assign row_past   = (row_reg >= (eff_h + HEIGHT_W'(1)));
    assign row_ge_h   = (row_reg >= eff_h);
    assign need_emit1 = col_is0 && (row_reg >= ROW_W'(2)) && !first_done_reg;
    assign need_emit2 = !col_is0 && (row_reg != '0);
    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign accept     = in_ch.valid && in_ch.ready;
    assign go         = ((in_ch.opcode == OP_PIXEL) && !row_ge_h)
                        || ((in_ch.opcode == OP_DRAIN) && row_ge_h);
    assign col_wrap   = ((WIDTH_W'(col_reg) + WIDTH_W'(1)) >= eff_w);

    assign in_ch.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && go)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (need_emit1)
                begin
                    state_next = ST_LUMA;
                end
                else if (col_is0 && row_past)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = need_emit2 ? ST_LUMA : ST_NEXT;
            end
            ST_LUMA:   state_next = ST_GRAD;
            ST_GRAD:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    state_next = emit_first_reg ? ST_ADV : ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if ((op_reg == OP_DRAIN) && !second_reg && row_ge_h)
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:  ctrl.ld_item = accept && go;
            ST_ADV:
            begin
                ctrl.ld_sel1 = need_emit1;
                ctrl.clr_cnt = !need_emit1 && col_is0 && row_past;
                ctrl.rd_en   = !need_emit1 && !(col_is0 && row_past);
            end
            ST_SHIFT: ctrl.do_shift = 1'b1;
            ST_EMIT:  ctrl.do_emit = !pend_valid_reg || slot_free;
            ST_NEXT:  ctrl.start_second = (op_reg == OP_DRAIN) && !second_reg && row_ge_h;
            ST_FLUSH: ctrl.flush_out = pend_valid_reg && slot_free;
            default:  ctrl = '0;
        endcase
    end

    // line memory
    assign mid_pix = rd_data_reg[PIX_W-1:0];
    assign new_pix = (op_reg == OP_DRAIN) ? mid_pix : pix_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.do_shift)
        begin
            line_mem[col_reg] <= {mid_pix, new_pix};
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    // window taps
    always_comb
    begin
        ri[0] = sel_reg.r0;
        ri[1] = 2'd1;
        ri[2] = sel_reg.r2;
        cj[0] = sel_reg.c0;
        cj[1] = sel_reg.c1;
        cj[2] = sel_reg.c2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k[i][j]      = win_reg[ri[i]][cj[j]];
                l_next[i][j] = luma(k[i][j]);
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            sharp_next[c*8 +: 8] = clamp8($signed(12'd5 * 12'(k[1][1][c*8 +: 8])
                - 12'(k[0][1][c*8 +: 8]) - 12'(k[2][1][c*8 +: 8])
                - 12'(k[1][0][c*8 +: 8]) - 12'(k[1][2][c*8 +: 8])));
        end
    end

    assign lap = THR_W'(4) * THR_W'(l_reg[1][1]) - THR_W'(l_reg[0][1])
                 - THR_W'(l_reg[2][1]) - THR_W'(l_reg[1][0]) - THR_W'(l_reg[1][2]);
    assign gx  = (THR_W'(l_reg[0][2]) + THR_W'(2) * THR_W'(l_reg[1][2]) + THR_W'(l_reg[2][2]))
                 - (THR_W'(l_reg[0][0]) + THR_W'(2) * THR_W'(l_reg[1][0])
                 + THR_W'(l_reg[2][0]));
    assign gy  = (THR_W'(l_reg[2][0]) + THR_W'(2) * THR_W'(l_reg[2][1]) + THR_W'(l_reg[2][2]))
                 - (THR_W'(l_reg[0][0]) + THR_W'(2) * THR_W'(l_reg[0][1])
                 + THR_W'(l_reg[0][2]));
    assign sq_sum = 17'(ax_reg) * 17'(ax_reg) + 17'(ay_reg) * 17'(ay_reg);
    assign trial  = {rem_reg, sq_v_reg[15:14]};
    assign test   = {1'b0, root_reg, 2'b01};

    // result selection
    always_comb
    begin
        case (mode_reg)
            MODE_SHARPEN:
            begin
                res.red   = sharp_reg[23:16];
                res.green = sharp_reg[15:8];
                res.blue  = sharp_reg[7:0];
            end
            MODE_EDGE:
            begin
                gray_val  = edge_reg ? 8'd255 : 8'd0;
                res.red   = gray_val;
                res.green = gray_val;
                res.blue  = gray_val;
            end
            MODE_SOBEL:
            begin
                gray_val  = sat_reg ? 8'd255 : root_reg;
                res.red   = gray_val;
                res.green = gray_val;
                res.blue  = gray_val;
            end
            default:
            begin
                res.red   = l_reg[1][1];
                res.green = l_reg[1][1];
                res.blue  = l_reg[1][1];
            end
        endcase
        if (mode_reg == MODE_SHARPEN)
        begin
            gray_val = 8'd0;
        end
        else if (mode_reg == MODE_EDGE)
        begin
            gray_val = edge_reg ? 8'd255 : 8'd0;
        end
        else if (mode_reg == MODE_SOBEL)
        begin
            gray_val = sat_reg ? 8'd255 : root_reg;
        end
        else
        begin
            gray_val = l_reg[1][1];
        end
        res.frame_end = (count_reg == frame_last_reg);
    end

    // compute pipeline payload
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_item)
        begin
            pix_reg <= {in_ch.pix_red, in_ch.pix_green, in_ch.pix_blue};
        end
        if (ctrl.ld_sel1)
        begin
            sel_reg.c0 <= (eff_w == WIDTH_W'(1)) ? 2'd2 : 2'd1;
            sel_reg.c1 <= 2'd2;
            sel_reg.c2 <= 2'd2;
            sel_reg.r0 <= (row_reg == ROW_W'(2)) ? 2'd1 : 2'd0;
            sel_reg.r2 <= (row_reg == (eff_h + HEIGHT_W'(1))) ? 2'd1 : 2'd2;
        end
        if (ctrl.do_shift)
        begin
            sel_reg.c0 <= (col_reg == COL_W'(1)) ? 2'd1 : 2'd0;
            sel_reg.c1 <= 2'd1;
            sel_reg.c2 <= 2'd2;
            sel_reg.r0 <= (row_reg == ROW_W'(1)) ? 2'd1 : 2'd0;
            sel_reg.r2 <= (row_reg == eff_h) ? 2'd1 : 2'd2;
        end
        if (state_reg == ST_LUMA)
        begin
            l_reg     <= l_next;
            sharp_reg <= sharp_next;
        end
        if (state_reg == ST_GRAD)
        begin
            edge_reg <= ($signed(lap) > thresh_reg);
            ax_reg   <= clamp8($signed({gx[THR_W-1], gx}));
            ay_reg   <= clamp8($signed({gy[THR_W-1], gy}));
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_v_reg <= sq_sum[15:0];
            sat_reg  <= sq_sum[16];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == ST_ROOT)
        begin
            sq_v_reg <= {sq_v_reg[13:0], 2'b00};
            if (trial >= test)
            begin
                rem_reg  <= 9'(trial - test);
                root_reg <= {root_reg[6:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[8:0];
                root_reg <= {root_reg[6:0], 1'b0};
            end
        end
        if (ctrl.do_emit)
        begin
            pend_reg <= res;
        end
        if ((ctrl.do_emit && pend_valid_reg) || ctrl.flush_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= ctrl.flush_out;
        end
    end

    // control state, counters, window, configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_SHARPEN;
            width_reg      <= WIDTH_W'(640);
            height_reg     <= HEIGHT_W'(480);
            thresh_reg     <= '0;
            frame_last_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            count_reg      <= '0;
            op_reg         <= OP_PIXEL;
            second_reg     <= 1'b0;
            first_done_reg <= 1'b0;
            emit_first_reg <= 1'b0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg      <= state_next;
            frame_last_reg <= CNT_W'(frame_size - (WIDTH_W+HEIGHT_W)'(1));

            if (ctrl.ld_item)
            begin
                op_reg         <= in_ch.opcode;
                second_reg     <= 1'b0;
                first_done_reg <= 1'b0;
            end
            if (ctrl.start_second)
            begin
                second_reg     <= 1'b1;
                first_done_reg <= 1'b0;
            end
            if (ctrl.ld_sel1)
            begin
                emit_first_reg <= 1'b1;
            end
            if (ctrl.clr_cnt)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                count_reg <= '0;
            end
            if (ctrl.do_shift)
            begin
                emit_first_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= rd_data_reg[LINE_W-1:PIX_W];
                win_reg[1][2] <= mid_pix;
                win_reg[2][2] <= new_pix;
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (state_reg == ST_SQUARE)
            begin
                step_reg <= '0;
            end
            if (state_reg == ST_ROOT)
            begin
                step_reg <= step_reg + 3'd1;
            end
            if (ctrl.do_emit)
            begin
                count_reg      <= count_reg + CNT_W'(1);
                pend_valid_reg <= 1'b1;
                if (emit_first_reg)
                begin
                    first_done_reg <= 1'b1;
                end
            end
            if (ctrl.flush_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((ctrl.do_emit && pend_valid_reg) || ctrl.flush_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:
                    begin
                        mode_reg <= mode_t'(cfg_wdata[1:0]);
                    end
                    REG_WIDTH:
                    begin
                        width_reg <= cfg_wdata[WIDTH_W-1:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                        count_reg <= '0;
                    end
                    REG_HEIGHT:
                    begin
                        height_reg <= cfg_wdata[HEIGHT_W-1:0];
                        col_reg    <= '0;
                        row_reg    <= '0;
                        count_reg  <= '0;
                    end
                    REG_THRESH:
                    begin
                        thresh_reg <= $signed(cfg_wdata[THR_W-1:0]);
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_red     = out_reg.red;
    assign out_ch.out_green   = out_reg.green;
    assign out_ch.out_blue    = out_reg.blue;
    assign out_ch.frame_end   = out_reg.frame_end;
    assign out_ch.last_of_run = out_last_reg;

endmodule

### hdl/cses_checker.sv
// Port-level checks for the 3x3 filter block, bound to its top level.
`include "conv3x3_sharpen_edge_sobel_top_assert.svh"

module cses_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic       out_last,
    input logic       out_frame_end
);

    `CSES_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `CSES_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_red))
    `CSES_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid)
    `CSES_ASSERT_IMP(a_end_last, out_valid && out_frame_end, out_last)

endmodule

bind conv3x3_sharpen_edge_sobel_top cses_checker u_cses_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_red       (out_ch.out_red),
    .out_last      (out_ch.last_of_run),
    .out_frame_end (out_ch.frame_end)
);
